[rtl/ids_pkg.sv]
package ids_pkg;

   // Character codes the scanner looks for.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_HASH  = 8'h23;

   // Index of the last letter of the keyword.
   localparam logic [2:0] KEYWORD_LAST = 3'd6;

   // Scan phase within one line.
   typedef enum logic [2:0] {
      PH_LINE_START,
      PH_AFTER_HASH,
      PH_KEYWORD,
      PH_AFTER_KEYWORD,
      PH_BEFORE_QUOTE,
      PH_NAME,
      PH_TAIL,
      PH_REST
   } phase_type;

   // Kind of line break seen on the previous byte.
   typedef enum logic [1:0] {
      BRK_NONE,
      BRK_CR,
      BRK_LF
   } break_type;

   // Control bits of one result word, passed from the scanner to the output stage.
   typedef struct packed {
      logic fire;
      logic record_valid;
      logic end_of_text;
   } res_ctrl_type;

   // Letters of the keyword "include".
   function automatic logic [7:0] keyword_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h69;
         3'd1: ch = 8'h6E;
         3'd2: ch = 8'h63;
         3'd3: ch = 8'h6C;
         3'd4: ch = 8'h75;
         3'd5: ch = 8'h64;
         3'd6: ch = 8'h65;
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

endpackage

[rtl/include_directive_scanner.sv]
// Scans a text one byte per word and reports each quoted include directive
// (optional blanks, '#', blanks, "include", a blank, blanks, a quoted name on
// the same line) when its line ends, together with the line and name offsets
// and the number of the following line. A zero byte ends the text: it always
// yields one end-of-text word, carrying any pending record, and clears the
// scanner. The block accepts one byte every cycle unless the input stalls; a result
// appears in the output register in the cycle after the byte that causes it. The
// input stalls only while that output register holds a word that the receiver stalls.
module include_directive_scanner #(
   parameter int OFFSET_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_char_code,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_record_valid,
   output logic                      rsp_end_of_text,
   output logic [OFFSET_BITS-1:0]    rsp_line_start,
   output logic [OFFSET_BITS-1:0]    rsp_line_end,
   output logic [OFFSET_BITS-1:0]    rsp_name_start,
   output logic [OFFSET_BITS-1:0]    rsp_name_length,
   output logic [OFFSET_BITS-1:0]    rsp_following_line
);

   logic                    accept;
   logic                    busy;
   ids_pkg::res_ctrl_type   res_ctrl;
   logic [OFFSET_BITS-1:0]  res_line_start;
   logic [OFFSET_BITS-1:0]  res_line_end;
   logic [OFFSET_BITS-1:0]  res_name_start;
   logic [OFFSET_BITS-1:0]  res_name_length;
   logic [OFFSET_BITS-1:0]  res_following_line;

   // Input handshake.
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   ids_scan #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_scan (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .char_code          (req_char_code),
      .res_ctrl           (res_ctrl),
      .res_line_start     (res_line_start),
      .res_line_end       (res_line_end),
      .res_name_start     (res_name_start),
      .res_name_length    (res_name_length),
      .res_following_line (res_following_line)
   );

   ids_out #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_out (
      .clock              (clock),
      .reset              (reset),
      .res_ctrl           (res_ctrl),
      .res_line_start     (res_line_start),
      .res_line_end       (res_line_end),
      .res_name_start     (res_name_start),
      .res_name_length    (res_name_length),
      .res_following_line (res_following_line),
      .rsp_stall          (rsp_stall),
      .busy               (busy),
      .rsp_valid          (rsp_valid),
      .rsp_record_valid   (rsp_record_valid),
      .rsp_end_of_text    (rsp_end_of_text),
      .rsp_line_start     (rsp_line_start),
      .rsp_line_end       (rsp_line_end),
      .rsp_name_start     (rsp_name_start),
      .rsp_name_length    (rsp_name_length),
      .rsp_following_line (rsp_following_line)
   );

   // A word on the output carries a record, the end of the text, or both.
   a_word_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_record_valid || rsp_end_of_text))
      else $error("result word with neither record nor end of text");

   // A terminator byte always shows up as an end-of-text word next cycle.
   a_terminator_reported: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_char_code == ids_pkg::CHAR_NUL)) |=>
      (rsp_valid && rsp_end_of_text))
      else $error("terminator byte produced no end-of-text word");

   // A record's offsets are ordered within its line.
   a_record_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_valid) |->
      ((rsp_line_start <= rsp_name_start) && (rsp_name_start <= rsp_line_end) &&
       (rsp_line_start <= rsp_line_end)))
      else $error("record offsets out of order");

   // Words without a record carry zero fields.
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_record_valid) |->
      ((rsp_line_start == '0) && (rsp_line_end == '0) && (rsp_name_start == '0) &&
       (rsp_name_length == '0) && (rsp_following_line == '0)))
      else $error("end-of-text word without record has nonzero fields");

endmodule

[rtl/ids_scan.sv]
module ids_scan #(
   parameter int OFFSET_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                char_code,
   output ids_pkg::res_ctrl_type     res_ctrl,
   output logic [OFFSET_BITS-1:0]    res_line_start,
   output logic [OFFSET_BITS-1:0]    res_line_end,
   output logic [OFFSET_BITS-1:0]    res_name_start,
   output logic [OFFSET_BITS-1:0]    res_name_length,
   output logic [OFFSET_BITS-1:0]    res_following_line
);

   localparam logic [OFFSET_BITS-1:0] CNT_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
   localparam logic [OFFSET_BITS-1:0] CNT_MAX = {OFFSET_BITS{1'b1}};

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_ONE;
   endfunction

   ids_pkg::phase_type      phase_ff, phase_in;
   ids_pkg::break_type      brk_ff, brk_in;
   logic [2:0]              kidx_ff, kidx_in;
   logic [OFFSET_BITS-1:0]  pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]  line_ff, line_in;
   logic [OFFSET_BITS-1:0]  cls_ff, cls_in;
   logic [OFFSET_BITS-1:0]  nstart_ff, nstart_in;
   logic [OFFSET_BITS-1:0]  nlen_ff, nlen_in;

   logic                    is_blank;
   logic                    is_break;
   logic                    paired;
   logic [OFFSET_BITS-1:0]  pos_inc;

   assign is_blank = char_code inside {ids_pkg::CHAR_SPACE, ids_pkg::CHAR_TAB};
   assign is_break = char_code inside {ids_pkg::CHAR_CR, ids_pkg::CHAR_LF};
   assign paired   = ((brk_ff == ids_pkg::BRK_CR) && (char_code == ids_pkg::CHAR_LF)) ||
                     ((brk_ff == ids_pkg::BRK_LF) && (char_code == ids_pkg::CHAR_CR));
   assign pos_inc  = sat_inc(pos_ff);

   // Next state: one byte advances the line scan by one step.
   always_comb begin
      phase_in  = phase_ff;
      brk_in    = brk_ff;
      kidx_in   = kidx_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      cls_in    = cls_ff;
      nstart_in = nstart_ff;
      nlen_in   = nlen_ff;
      if (accept) begin
         if (char_code == ids_pkg::CHAR_NUL) begin
            // The terminator returns everything to its reset state.
            phase_in  = ids_pkg::PH_LINE_START;
            brk_in    = ids_pkg::BRK_NONE;
            kidx_in   = 3'd0;
            pos_in    = '0;
            line_in   = CNT_ONE;
            cls_in    = '0;
            nstart_in = '0;
            nlen_in   = '0;
         end else if (paired) begin
            // Second half of a CR LF or LF CR pair.
            brk_in = ids_pkg::BRK_NONE;
            cls_in = pos_inc;
            pos_in = pos_inc;
         end else if (is_break) begin
            brk_in   = (char_code == ids_pkg::CHAR_CR) ? ids_pkg::BRK_CR : ids_pkg::BRK_LF;
            phase_in = ids_pkg::PH_LINE_START;
            kidx_in  = 3'd0;
            line_in  = sat_inc(line_ff);
            cls_in   = pos_inc;
            pos_in   = pos_inc;
         end else begin
            brk_in = ids_pkg::BRK_NONE;
            pos_in = pos_inc;
            case (phase_ff)
               ids_pkg::PH_LINE_START: begin
                  if (char_code == ids_pkg::CHAR_HASH) begin
                     phase_in = ids_pkg::PH_AFTER_HASH;
                  end else if (!is_blank) begin
                     phase_in = ids_pkg::PH_REST;
                  end
               end
               ids_pkg::PH_AFTER_HASH: begin
                  if (char_code == ids_pkg::keyword_char(3'd0)) begin
                     phase_in = ids_pkg::PH_KEYWORD;
                     kidx_in  = 3'd1;
                  end else if (!is_blank) begin
                     phase_in = ids_pkg::PH_REST;
                  end
               end
               ids_pkg::PH_KEYWORD: begin
                  if (char_code == ids_pkg::keyword_char(kidx_ff)) begin
                     if (kidx_ff == ids_pkg::KEYWORD_LAST) begin
                        phase_in = ids_pkg::PH_AFTER_KEYWORD;
                        kidx_in  = 3'd0;
                     end else begin
                        kidx_in = kidx_ff + 3'd1;
                     end
                  end else begin
                     phase_in = ids_pkg::PH_REST;
                     kidx_in  = 3'd0;
                  end
               end
               ids_pkg::PH_AFTER_KEYWORD: begin
                  phase_in = is_blank ? ids_pkg::PH_BEFORE_QUOTE : ids_pkg::PH_REST;
               end
               ids_pkg::PH_BEFORE_QUOTE: begin
                  if (char_code == ids_pkg::CHAR_QUOTE) begin
                     phase_in  = ids_pkg::PH_NAME;
                     nstart_in = pos_inc;
                     nlen_in   = '0;
                  end else if (!is_blank) begin
                     phase_in = ids_pkg::PH_REST;
                  end
               end
               ids_pkg::PH_NAME: begin
                  if (char_code == ids_pkg::CHAR_QUOTE) begin
                     phase_in = ids_pkg::PH_TAIL;
                  end else begin
                     nlen_in = sat_inc(nlen_ff);
                  end
               end
               ids_pkg::PH_TAIL: begin
                  phase_in = ids_pkg::PH_TAIL;
               end
               default: begin
                  phase_in = ids_pkg::PH_REST;
               end
            endcase
         end
      end
   end

   // Result word: a record leaves when its line ends or the text ends.
   always_comb begin
      res_ctrl           = '0;
      res_line_start     = '0;
      res_line_end       = '0;
      res_name_start     = '0;
      res_name_length    = '0;
      res_following_line = '0;
      if (accept) begin
         if (char_code == ids_pkg::CHAR_NUL) begin
            res_ctrl.fire         = 1'b1;
            res_ctrl.end_of_text  = 1'b1;
            res_ctrl.record_valid = (phase_ff == ids_pkg::PH_TAIL);
         end else if (is_break && !paired) begin
            res_ctrl.fire         = (phase_ff == ids_pkg::PH_TAIL);
            res_ctrl.record_valid = (phase_ff == ids_pkg::PH_TAIL);
         end
      end
      if (res_ctrl.record_valid) begin
         res_line_start     = cls_ff;
         res_line_end       = pos_ff;
         res_name_start     = nstart_ff;
         res_name_length    = nlen_ff;
         res_following_line = sat_inc(line_ff);
      end
   end

   // Scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ids_pkg::PH_LINE_START;
         brk_ff    <= ids_pkg::BRK_NONE;
         kidx_ff   <= 3'd0;
         pos_ff    <= '0;
         line_ff   <= CNT_ONE;
         cls_ff    <= '0;
         nstart_ff <= '0;
         nlen_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         brk_ff    <= brk_in;
         kidx_ff   <= kidx_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         cls_ff    <= cls_in;
         nstart_ff <= nstart_in;
         nlen_ff   <= nlen_in;
      end
   end

endmodule

[rtl/ids_out.sv]
module ids_out #(
   parameter int OFFSET_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ids_pkg::res_ctrl_type     res_ctrl,
   input  logic [OFFSET_BITS-1:0]    res_line_start,
   input  logic [OFFSET_BITS-1:0]    res_line_end,
   input  logic [OFFSET_BITS-1:0]    res_name_start,
   input  logic [OFFSET_BITS-1:0]    res_name_length,
   input  logic [OFFSET_BITS-1:0]    res_following_line,
   input  logic                      rsp_stall,
   output logic                      busy,
   output logic                      rsp_valid,
   output logic                      rsp_record_valid,
   output logic                      rsp_end_of_text,
   output logic [OFFSET_BITS-1:0]    rsp_line_start,
   output logic [OFFSET_BITS-1:0]    rsp_line_end,
   output logic [OFFSET_BITS-1:0]    rsp_name_start,
   output logic [OFFSET_BITS-1:0]    rsp_name_length,
   output logic [OFFSET_BITS-1:0]    rsp_following_line
);

   logic                    valid_ff, valid_in;
   logic                    rec_ff;
   logic                    eot_ff;
   logic [OFFSET_BITS-1:0]  lstart_ff;
   logic [OFFSET_BITS-1:0]  lend_ff;
   logic [OFFSET_BITS-1:0]  nstart_ff;
   logic [OFFSET_BITS-1:0]  nlen_ff;
   logic [OFFSET_BITS-1:0]  nline_ff;

   // The register is full and its word is held this cycle.
   assign busy = valid_ff && rsp_stall;

   // Load a new word, hold a stalled one, or drain.
   always_comb begin
      if (res_ctrl.fire) begin
         valid_in = 1'b1;
      end else begin
         valid_in = busy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (res_ctrl.fire) begin
         rec_ff    <= res_ctrl.record_valid;
         eot_ff    <= res_ctrl.end_of_text;
         lstart_ff <= res_line_start;
         lend_ff   <= res_line_end;
         nstart_ff <= res_name_start;
         nlen_ff   <= res_name_length;
         nline_ff  <= res_following_line;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_record_valid   = rec_ff;
   assign rsp_end_of_text    = eot_ff;
   assign rsp_line_start     = lstart_ff;
   assign rsp_line_end       = lend_ff;
   assign rsp_name_start     = nstart_ff;
   assign rsp_name_length    = nlen_ff;
   assign rsp_following_line = nline_ff;

endmodule

[test/tb_include_directive_scanner.sv]
`timescale 1ns / 100ps

module tb_include_directive_scanner;

   localparam int OFFSET_BITS   = 24;
   localparam int STALL_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int BYTES_PER_RUN = 175;
   localparam logic [55:0] KEYWORD_TEXT = "include";

   // Ways in which a generated directive line can go wrong.
   typedef enum int {
      FLAW_NONE,
      FLAW_KEYWORD_BREAK,
      FLAW_BAD_LETTER,
      FLAW_NO_BLANK,
      FLAW_JUNK_BEFORE_QUOTE,
      FLAW_OPEN_NAME,
      FLAW_JUNK_BEFORE_HASH
   } directive_flaw_type;

   typedef struct packed {
      logic                   record_valid;
      logic                   end_of_text;
      logic [OFFSET_BITS-1:0] line_start;
      logic [OFFSET_BITS-1:0] line_end;
      logic [OFFSET_BITS-1:0] name_start;
      logic [OFFSET_BITS-1:0] name_length;
      logic [OFFSET_BITS-1:0] following_line;
   } scan_result_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_char_code = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_record_valid;
   logic                   rsp_end_of_text;
   logic [OFFSET_BITS-1:0] rsp_line_start;
   logic [OFFSET_BITS-1:0] rsp_line_end;
   logic [OFFSET_BITS-1:0] rsp_name_start;
   logic [OFFSET_BITS-1:0] rsp_name_length;
   logic [OFFSET_BITS-1:0] rsp_following_line;

   // Text bytes waiting to be sent and results the scanner still owes.
   logic [7:0]      text_bytes[$];
   scan_result_type expected_results[$];
   int              bytes_queued = 0;
   int              mismatches = 0;
   int              quiet_cycles = 0;
   int              sender_gap_pct = 0;
   int              receiver_stall_pct = 0;
   logic            byte_taken = 1'b0;

   // Shadow copy of the scanner state.
   ids_pkg::phase_type     scan_phase;
   ids_pkg::break_type     last_break;
   logic [2:0]             kw_pos;
   logic [OFFSET_BITS-1:0] scan_pos;
   logic [OFFSET_BITS-1:0] scan_line;
   logic [OFFSET_BITS-1:0] line_begin;
   logic [OFFSET_BITS-1:0] name_begin;
   logic [OFFSET_BITS-1:0] name_len;

   include_directive_scanner #(.OFFSET_BITS(OFFSET_BITS)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_record_valid  (rsp_record_valid),
      .rsp_end_of_text   (rsp_end_of_text),
      .rsp_line_start    (rsp_line_start),
      .rsp_line_end      (rsp_line_end),
      .rsp_name_start    (rsp_name_start),
      .rsp_name_length   (rsp_name_length),
      .rsp_following_line(rsp_following_line)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [OFFSET_BITS-1:0] saturating_inc(logic [OFFSET_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [7:0] keyword_letter(logic [2:0] k);
      return KEYWORD_TEXT[8 * (int'(ids_pkg::KEYWORD_LAST) - int'(k)) +: 8];
   endfunction

   function automatic logic is_blank(logic [7:0] ch);
      return ch == ids_pkg::CHAR_SPACE || ch == ids_pkg::CHAR_TAB;
   endfunction

   task automatic clear_scanner();
      scan_phase = ids_pkg::PH_LINE_START;
      last_break = ids_pkg::BRK_NONE;
      kw_pos     = '0;
      scan_pos   = '0;
      scan_line  = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
      line_begin = '0;
      name_begin = '0;
      name_len   = '0;
   endtask

   // Record for the current line, as it is reported once the line ends.
   function automatic scan_result_type found_record();
      scan_result_type r;
      r                = '0;
      r.record_valid   = 1'b1;
      r.line_start     = line_begin;
      r.line_end       = scan_pos;
      r.name_start     = name_begin;
      r.name_length    = name_len;
      r.following_line = saturating_inc(scan_line);
      return r;
   endfunction

   // Advances the shadow scanner by one text byte and queues any result it causes.
   task automatic scan_byte(logic [7:0] ch);
      scan_result_type r;
      logic            paired;
      paired = 1'b0;
      if (ch == ids_pkg::CHAR_NUL) begin
         r = (scan_phase == ids_pkg::PH_TAIL) ? found_record() : '0;
         r.end_of_text = 1'b1;
         expected_results.push_back(r);
         clear_scanner();
         return;
      end
      // The second half of a CR LF or LF CR pair only moves the line start and the position.
      if (last_break != ids_pkg::BRK_NONE) begin
         paired = (last_break == ids_pkg::BRK_CR && ch == ids_pkg::CHAR_LF) ||
                  (last_break == ids_pkg::BRK_LF && ch == ids_pkg::CHAR_CR);
         last_break = ids_pkg::BRK_NONE;
      end
      if (paired) begin
         line_begin = saturating_inc(scan_pos);
         scan_pos   = saturating_inc(scan_pos);
      end else if (ch == ids_pkg::CHAR_CR || ch == ids_pkg::CHAR_LF) begin
         if (scan_phase == ids_pkg::PH_TAIL)
            expected_results.push_back(found_record());
         last_break = (ch == ids_pkg::CHAR_CR) ? ids_pkg::BRK_CR : ids_pkg::BRK_LF;
         scan_phase = ids_pkg::PH_LINE_START;
         kw_pos     = '0;
         scan_line  = saturating_inc(scan_line);
         line_begin = saturating_inc(scan_pos);
         scan_pos   = saturating_inc(scan_pos);
      end else begin
         case (scan_phase)
            ids_pkg::PH_LINE_START: begin
               if (ch == ids_pkg::CHAR_HASH)
                  scan_phase = ids_pkg::PH_AFTER_HASH;
               else if (!is_blank(ch))
                  scan_phase = ids_pkg::PH_REST;
            end
            ids_pkg::PH_AFTER_HASH: begin
               if (ch == keyword_letter(3'd0)) begin
                  scan_phase = ids_pkg::PH_KEYWORD;
                  kw_pos     = 3'd1;
               end else if (!is_blank(ch)) begin
                  scan_phase = ids_pkg::PH_REST;
               end
            end
            ids_pkg::PH_KEYWORD: begin
               if (ch == keyword_letter(kw_pos)) begin
                  if (kw_pos == ids_pkg::KEYWORD_LAST) begin
                     scan_phase = ids_pkg::PH_AFTER_KEYWORD;
                     kw_pos     = '0;
                  end else begin
                     kw_pos = kw_pos + 1'b1;
                  end
               end else begin
                  scan_phase = ids_pkg::PH_REST;
                  kw_pos     = '0;
               end
            end
            ids_pkg::PH_AFTER_KEYWORD: begin
               scan_phase = is_blank(ch) ? ids_pkg::PH_BEFORE_QUOTE : ids_pkg::PH_REST;
            end
            ids_pkg::PH_BEFORE_QUOTE: begin
               if (ch == ids_pkg::CHAR_QUOTE) begin
                  scan_phase = ids_pkg::PH_NAME;
                  name_begin = saturating_inc(scan_pos);
                  name_len   = '0;
               end else if (!is_blank(ch)) begin
                  scan_phase = ids_pkg::PH_REST;
               end
            end
            ids_pkg::PH_NAME: begin
               if (ch == ids_pkg::CHAR_QUOTE)
                  scan_phase = ids_pkg::PH_TAIL;
               else
                  name_len = saturating_inc(name_len);
            end
            ids_pkg::PH_TAIL: begin
            end
            default: begin
               scan_phase = ids_pkg::PH_REST;
            end
         endcase
         scan_pos = saturating_inc(scan_pos);
      end
   endtask

   task automatic queue_byte(logic [7:0] b);
      text_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_text(string s);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s[i]);
   endtask

   task automatic queue_blanks(int most);
      repeat ($urandom_range(0, most))
         queue_byte($urandom_range(0, 1) ? ids_pkg::CHAR_SPACE : ids_pkg::CHAR_TAB);
   endtask

   // Any byte that does not end the text or the line and, unless quotes are allowed, is no quote.
   function automatic logic [7:0] plain_byte(logic allow_quote);
      logic [7:0] b;
      do
         b = 8'($urandom_range(1, 255));
      while (b == ids_pkg::CHAR_CR || b == ids_pkg::CHAR_LF ||
             (!allow_quote && b == ids_pkg::CHAR_QUOTE));
      return b;
   endfunction

   task automatic queue_break();
      case ($urandom_range(0, 3))
         0: queue_byte(ids_pkg::CHAR_LF);
         1: queue_byte(ids_pkg::CHAR_CR);
         2: begin
            queue_byte(ids_pkg::CHAR_CR);
            queue_byte(ids_pkg::CHAR_LF);
         end
         default: begin
            queue_byte(ids_pkg::CHAR_LF);
            queue_byte(ids_pkg::CHAR_CR);
         end
      endcase
   endtask

   // One directive line with random content, well formed or broken in one place.
   task automatic queue_directive(directive_flaw_type flaw);
      int cut;
      cut = $urandom_range(0, 6);
      queue_blanks(3);
      if (flaw == FLAW_JUNK_BEFORE_HASH)
         queue_byte(plain_byte(1'b1));
      queue_byte(ids_pkg::CHAR_HASH);
      queue_blanks(2);
      if (flaw == FLAW_KEYWORD_BREAK) begin
         for (int k = 0; k < cut; k++)
            queue_byte(keyword_letter(3'(k)));
         return;
      end
      for (int k = 0; k <= ids_pkg::KEYWORD_LAST; k++)
         queue_byte((flaw == FLAW_BAD_LETTER && k == cut) ? plain_byte(1'b1)
                                                          : keyword_letter(3'(k)));
      if (flaw == FLAW_NO_BLANK) begin
         queue_byte(plain_byte(1'b1));
      end else begin
         queue_byte($urandom_range(0, 1) ? ids_pkg::CHAR_SPACE : ids_pkg::CHAR_TAB);
         queue_blanks(2);
      end
      if (flaw == FLAW_JUNK_BEFORE_QUOTE)
         queue_byte(plain_byte(1'b0));
      queue_byte(ids_pkg::CHAR_QUOTE);
      repeat ($urandom_range(0, 6))
         queue_byte(plain_byte(1'b0));
      if (flaw != FLAW_OPEN_NAME) begin
         queue_byte(ids_pkg::CHAR_QUOTE);
         repeat ($urandom_range(0, 4))
            queue_byte(plain_byte(1'b1));
      end
   endtask

   // A text of a few lines, mostly directives, closed by the zero byte.
   task automatic queue_random_text(int lines);
      int pick;
      repeat (lines) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            queue_directive(FLAW_NONE);
         else if (pick < 72)
            queue_directive(directive_flaw_type'($urandom_range(1, 6)));
         else if (pick < 87)
            repeat ($urandom_range(1, 8)) queue_byte(plain_byte(1'b1));
         else
            queue_blanks(2);
         if ($urandom_range(0, 5) != 0)
            queue_break();
      end
      queue_byte(ids_pkg::CHAR_NUL);
   endtask

   // Holds off until every queued word has been sent and every result has come back.
   task automatic wait_for_drain();
      while (text_bytes.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   function automatic void check_field(string field, logic [OFFSET_BITS-1:0] want,
                                       logic [OFFSET_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // Driver: presents the next text byte once the previous word has been taken, and draws the receiver stall.
   always @(negedge clock) begin : drive_words
      logic       next_valid;
      logic [7:0] next_char;
      next_valid = req_valid;
      next_char  = req_char_code;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || byte_taken) begin
         next_valid = 1'b0;
         if (text_bytes.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
            next_valid = 1'b1;
            next_char  = text_bytes.pop_front();
         end
      end
      req_valid     <= next_valid;
      req_char_code <= next_char;
      rsp_stall     <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Monitor: predicts on each accepted byte and checks each accepted result word.
   always @(posedge clock) begin : watch_words
      scan_result_type want;
      logic            result_taken;
      if (reset) begin
         clear_scanner();
         byte_taken   = 1'b0;
         quiet_cycles = 0;
      end else begin
         byte_taken   = req_valid && !req_stall;
         result_taken = rsp_valid && !rsp_stall;
         if (byte_taken)
            scan_byte(req_char_code);
         if (result_taken) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result word with none expected, record_valid %0d end_of_text %0d",
                        $time, rsp_record_valid, rsp_end_of_text);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("record_valid", OFFSET_BITS'(want.record_valid),
                           OFFSET_BITS'(rsp_record_valid));
               check_field("end_of_text", OFFSET_BITS'(want.end_of_text),
                           OFFSET_BITS'(rsp_end_of_text));
               check_field("line_start", want.line_start, rsp_line_start);
               check_field("line_end", want.line_end, rsp_line_end);
               check_field("name_start", want.name_start, rsp_name_start);
               check_field("name_length", want.name_length, rsp_name_length);
               check_field("following_line", want.following_line, rsp_following_line);
            end
         end
         // Watchdog on cycles in which neither channel moves a word.
         if (byte_taken || result_taken) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
               $display("CHECKS FAILED");
               $finish;
            end
         end
      end
   end

   // Stimulus: a directed opening, then random texts in four runs with different sender gaps and receiver stalls.
   initial begin : run_texts
      int gap_pct[4];
      int stall_pct[4];
      gap_pct   = '{0, 83, 0, 12};
      stall_pct = '{0, 0, 83, 12};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int run = 0; run < 4; run++) begin
         sender_gap_pct     = gap_pct[run];
         receiver_stall_pct = stall_pct[run];
         if (run == 0) begin
            // Empty text, extreme byte values, both paired breaks, and a directive with an
            // empty name whose line is ended only by the terminator.
            queue_byte(ids_pkg::CHAR_NUL);
            queue_byte(8'hFF);
            queue_byte(8'h80);
            queue_byte(ids_pkg::CHAR_CR);
            queue_byte(ids_pkg::CHAR_LF);
            queue_byte(ids_pkg::CHAR_LF);
            queue_byte(ids_pkg::CHAR_CR);
            queue_byte(ids_pkg::CHAR_NUL);
            queue_text("#include \"\"");
            queue_byte(ids_pkg::CHAR_NUL);
         end
         while (bytes_queued < (run + 1) * BYTES_PER_RUN)
            queue_random_text($urandom_range(1, 6));
         // The sender waits here until the scanner has delivered everything.
         wait_for_drain();
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
